// ----- design/irhf_pkg.sv -----
// ----------------------------------------------------------------------------
// irhf_pkg
// Types and constants shared by the IPv4 receive header filter.
// ----------------------------------------------------------------------------
`default_nettype none

package irhf_pkg;

    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOCAL_ADDR = 1'b0,
        REG_NET_MASK   = 1'b1
    } cfg_reg_t;

    localparam logic [31:0] LOCAL_ADDR_RESET = 32'h0000_0000;
    localparam logic [31:0] NET_MASK_RESET   = 32'hffff_ff00;
    localparam logic [31:0] LIMITED_BCAST    = 32'hffff_ffff;

    localparam logic [15:0] COUNT_MAX  = 16'hffff;
    localparam logic [15:0] SUM_VALID  = 16'hffff;
    localparam logic [3:0]  MIN_IHL    = 4'd5;
    localparam logic [3:0]  IP_VERSION = 4'd4;

    localparam logic [15:0] IDX_VER_IHL = 16'd0;
    localparam logic [15:0] IDX_TLEN_HI = 16'd2;
    localparam logic [15:0] IDX_TLEN_LO = 16'd3;
    localparam logic [15:0] IDX_PROTO   = 16'd9;
    localparam logic [15:0] IDX_SRC_LO  = 16'd12;
    localparam logic [15:0] IDX_SRC_HI  = 16'd15;
    localparam logic [15:0] IDX_DST_LO  = 16'd16;
    localparam logic [15:0] IDX_DST_HI  = 16'd19;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [3:0] {
        VERDICT_TCP       = 4'd0,
        VERDICT_UDP       = 4'd1,
        VERDICT_ICMP      = 4'd2,
        VERDICT_HDR_SHORT = 4'd3,
        VERDICT_HDR_TRUNC = 4'd4,
        VERDICT_LEN_OVER  = 4'd5,
        VERDICT_CHECKSUM  = 4'd6,
        VERDICT_VERSION   = 4'd7,
        VERDICT_ADDRESS   = 4'd8,
        VERDICT_PROTOCOL  = 4'd9
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [5:0]  header_bytes;
        logic [15:0] payload_length;
        logic [31:0] source_addr;
        logic [31:0] target_addr;
    } out_item_t;

    // header fields of one finished packet, handed from parser to judge
    typedef struct packed {
        logic [15:0] frame_bytes;
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [15:0] total_length;
        logic [15:0] checksum;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
    } hdr_snap_t;

endpackage

`default_nettype wire

// ----- design/irhf_parser.sv -----
// ----------------------------------------------------------------------------
// irhf_parser
// Byte-wise header capture and ones' complement checksum accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module irhf_parser
    import irhf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_payload,
    output logic           snap_valid,
    input  wire logic      snap_ready,
    output hdr_snap_t      snap
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [3:0]  version_reg, version_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic        snap_valid_reg, snap_valid_next;
    hdr_snap_t   snap_reg, snap_next;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] count_inc;
    logic [3:0]  ihl_cur;
    logic [5:0]  hdr_len;
    logic [16:0] sum_wide;
    logic [15:0] sum_fold;

    assign s_ready    = !snap_valid_reg || snap_ready;
    assign accept     = s_valid && s_ready;
    assign b          = s_payload.data_byte;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    always_comb begin
        count_inc = (byte_count_reg == COUNT_MAX) ? COUNT_MAX : byte_count_reg + 16'd1;
        // IHL is taken from the first byte itself when that byte is the one in flight
        ihl_cur   = (byte_count_reg == IDX_VER_IHL) ? b[3:0] : ihl_reg;
        hdr_len   = {ihl_cur, 2'b00};
        sum_wide  = {1'b0, sum_reg} + {1'b0, hold_reg, b};
        // end-around carry: subtracting 0xffff is dropping bit 16 and adding one
        sum_fold  = sum_wide[16] ? sum_wide[15:0] + 16'd1 : sum_wide[15:0];

        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        hold_next       = hold_reg;
        version_next    = version_reg;
        ihl_next        = ihl_reg;
        total_next      = total_reg;
        proto_next      = proto_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        snap_valid_next = snap_ready ? 1'b0 : snap_valid_reg;
        snap_next       = snap_reg;

        if (accept) begin
            byte_count_next = count_inc;
            if (byte_count_reg == IDX_VER_IHL) begin
                version_next = b[7:4];
                ihl_next     = b[3:0];
            end
            if (byte_count_reg == IDX_TLEN_HI || byte_count_reg == IDX_TLEN_LO) begin
                total_next = {total_reg[7:0], b};
            end
            if (byte_count_reg == IDX_PROTO) begin
                proto_next = b;
            end
            if (byte_count_reg >= IDX_SRC_LO && byte_count_reg <= IDX_SRC_HI) begin
                src_next = {src_reg[23:0], b};
            end
            if (byte_count_reg >= IDX_DST_LO && byte_count_reg <= IDX_DST_HI) begin
                dst_next = {dst_reg[23:0], b};
            end
            if (byte_count_reg < {10'd0, hdr_len}) begin
                if (!byte_count_reg[0]) begin
                    hold_next = b;
                end else begin
                    sum_next = sum_fold;
                end
            end

            if (s_payload.last_byte) begin
                snap_valid_next          = 1'b1;
                snap_next.frame_bytes    = count_inc;
                snap_next.version        = version_next;
                snap_next.ihl            = ihl_next;
                snap_next.total_length   = total_next;
                snap_next.checksum       = sum_next;
                snap_next.proto          = proto_next;
                snap_next.src            = src_next;
                snap_next.dst            = dst_next;
                byte_count_next = '0;
                sum_next        = '0;
                hold_next       = '0;
                version_next    = '0;
                ihl_next        = '0;
                total_next      = '0;
                proto_next      = '0;
                src_next        = '0;
                dst_next        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            hold_reg       <= '0;
            version_reg    <= '0;
            ihl_reg        <= '0;
            total_reg      <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            hold_reg       <= hold_next;
            version_reg    <= version_next;
            ihl_reg        <= ihl_next;
            total_reg      <= total_next;
            proto_reg      <= proto_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

`ifndef SYNTHESIS
    a_last_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_payload.last_byte) |=> (byte_count_reg == '0 && snap_valid_reg))
        else $error("parser did not close the packet after the last byte");

    a_snap_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid_reg |-> (snap_reg.frame_bytes != '0))
        else $error("finished packet reports zero frame bytes");
`endif

endmodule

`default_nettype wire

// ----- design/irhf_judge.sv -----
// ----------------------------------------------------------------------------
// irhf_judge
// Verdict, payload length and result register for one finished header.
// ----------------------------------------------------------------------------
`default_nettype none

module irhf_judge
    import irhf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [31:0] local_addr,
    input  wire logic [31:0] net_mask,
    input  wire logic        snap_valid,
    output logic             snap_ready,
    input  wire hdr_snap_t   snap,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_payload
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [5:0]  hdr_len;
    logic [15:0] hdr_len16;
    logic [15:0] eff_len;
    logic [31:0] host_bits;
    logic        is_bcast;
    logic        addr_ok;
    verdict_t    verdict;

    assign snap_ready = !out_valid_reg || m_ready;
    assign m_valid    = out_valid_reg;
    assign m_payload  = out_reg;

    always_comb begin
        hdr_len   = {snap.ihl, 2'b00};
        hdr_len16 = {10'd0, hdr_len};
        eff_len   = (snap.total_length < snap.frame_bytes) ? snap.total_length
                                                           : snap.frame_bytes;
        host_bits = ~net_mask;
        is_bcast  = (snap.dst & host_bits) == host_bits;

        if (local_addr == '0) begin
            addr_ok = (snap.dst == LIMITED_BCAST);
        end else if (is_bcast) begin
            addr_ok = (snap.proto == PROTO_UDP);
        end else begin
            addr_ok = (snap.dst == local_addr);
        end

        if (snap.ihl < MIN_IHL) begin
            verdict = VERDICT_HDR_SHORT;
        end else if (hdr_len16 > snap.frame_bytes) begin
            verdict = VERDICT_HDR_TRUNC;
        end else if (snap.total_length > snap.frame_bytes) begin
            verdict = VERDICT_LEN_OVER;
        end else if (snap.checksum != SUM_VALID) begin
            verdict = VERDICT_CHECKSUM;
        end else if (snap.version != IP_VERSION) begin
            verdict = VERDICT_VERSION;
        end else if (!addr_ok) begin
            verdict = VERDICT_ADDRESS;
        end else if (snap.proto == PROTO_TCP) begin
            verdict = VERDICT_TCP;
        end else if (snap.proto == PROTO_UDP) begin
            verdict = VERDICT_UDP;
        end else if (snap.proto == PROTO_ICMP) begin
            verdict = VERDICT_ICMP;
        end else begin
            verdict = VERDICT_PROTOCOL;
        end

        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        out_next       = out_reg;
        if (snap_valid && snap_ready) begin
            out_valid_next          = 1'b1;
            out_next.verdict        = verdict;
            out_next.header_bytes   = hdr_len;
            out_next.payload_length = (eff_len > hdr_len16) ? eff_len - hdr_len16 : '0;
            out_next.source_addr    = snap.src;
            out_next.target_addr    = snap.dst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_delivered_full_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.verdict == VERDICT_TCP || out_reg.verdict == VERDICT_UDP
                           || out_reg.verdict == VERDICT_ICMP))
        |-> (out_reg.header_bytes >= 6'd20))
        else $error("packet delivered with a header shorter than the minimum");
`endif

endmodule

`default_nettype wire

// ----- design/ipv4_receive_header_filter.sv -----
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter
// IPv4 receive header check: parse, checksum, address filter, verdict.
// ----------------------------------------------------------------------------
// Takes one byte of the IP packet per transaction, starting right after the
// Ethernet header, with last_byte marking the end of the frame. A new byte is
// accepted every cycle while s_ready is high; the parser updates its header
// fields and checksum on the byte itself and registers the finished header at
// the edge that accepts the last byte, and the judge stage registers the
// verdict from that header once its result register is free, raising m_valid.
// s_ready drops only while a finished header and a verdict are both held
// waiting on m_ready. Only the last byte produces a result transaction. Write
// local_addr and net_mask only while no frame is in flight.
`default_nettype none

module ipv4_receive_header_filter
    import irhf_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_payload,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_payload,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    logic [31:0] local_addr_reg, local_addr_next;
    logic [31:0] net_mask_reg, net_mask_next;
    logic        snap_valid;
    logic        snap_ready;
    hdr_snap_t   snap;

    assign cfg_ready = 1'b1;

    always_comb begin
        local_addr_next = local_addr_reg;
        net_mask_next   = net_mask_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_LOCAL_ADDR: local_addr_next = cfg_data;
                REG_NET_MASK:   net_mask_next   = cfg_data;
                default: begin
                    local_addr_next = local_addr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg <= LOCAL_ADDR_RESET;
            net_mask_reg   <= NET_MASK_RESET;
        end else begin
            local_addr_reg <= local_addr_next;
            net_mask_reg   <= net_mask_next;
        end
    end

    irhf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    irhf_judge u_judge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .local_addr (local_addr_reg),
        .net_mask   (net_mask_reg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

`default_nettype wire
